// ----- hdl/psu_pkg.sv -----
// ----------------------------------------------------------------------------
// PNG scanline unfilter - shared definitions
// Filter codes, control struct and default sizes used by the front end,
// the queue and the reconstruction back end.
// ----------------------------------------------------------------------------
package psu_pkg;

   localparam int PSU_MAX_ROW_BYTES   = 8192;
   localparam int PSU_MAX_PIXEL_BYTES = 8;
   localparam int PSU_QUEUE_DEPTH     = 2;

   // configuration register indexes
   localparam logic [3:0] CSR_BYTES_PER_PIXEL = 4'd0;
   localparam logic [3:0] CSR_ROW_BYTES       = 4'd1;

   localparam logic [3:0]  BPP_RESET       = 4'd4;
   localparam logic [13:0] ROW_BYTES_RESET = 14'd1024;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4,
      FILT_BAD   = 3'd5
   } psu_filt_type;

   // one data byte on its way from the front end to the back end
   typedef struct packed {
      logic [7:0]   data;
      psu_filt_type filt;
      logic         first_row;
      logic         row_start;
      logic         last;
   } psu_ctl_type;

endpackage

// ----- hdl/psu_front.sv -----
// ----------------------------------------------------------------------------
// PNG scanline unfilter - front end
// Takes the byte stream, consumes filter-type bytes, tracks the column and
// tags each data byte with its filter, row position and end of row.
// ----------------------------------------------------------------------------
module psu_front import psu_pkg::*; #(
   parameter int MAX_ROW_BYTES = PSU_MAX_ROW_BYTES,
   localparam int ADDR_W = $clog2(MAX_ROW_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [13:0]       row_bytes,
   input  logic              in_accept,
   input  logic [7:0]        in_byte,
   input  logic              image_start,
   output logic              item_valid,
   output psu_ctl_type       item_ctl,
   output logic [ADDR_W-1:0] item_col
);

   localparam int CW = (ADDR_W + 1 > 14) ? ADDR_W + 1 : 14;

   logic              awaiting_ff, awaiting_in;
   logic              first_row_ff, first_row_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   psu_filt_type      filt_ff, filt_in;

   logic          awaiting_eff;
   logic          first_eff;
   logic [CW-1:0] rb_ext;
   logic [CW-1:0] rb_eff;
   logic          last;

   assign awaiting_eff = image_start | awaiting_ff;
   assign first_eff    = image_start | first_row_ff;

   // clamp row length into 1..MAX_ROW_BYTES
   assign rb_ext = CW'(row_bytes);
   always_comb begin
      if (rb_ext == '0) begin
         rb_eff = CW'(1);
      end else if (rb_ext > CW'(MAX_ROW_BYTES)) begin
         rb_eff = CW'(MAX_ROW_BYTES);
      end else begin
         rb_eff = rb_ext;
      end
   end

   assign last = (CW'(col_ff) + CW'(1)) >= rb_eff;

   assign item_valid         = in_accept & ~awaiting_eff;
   assign item_ctl.data      = in_byte;
   assign item_ctl.filt      = filt_ff;
   assign item_ctl.first_row = first_row_ff;
   assign item_ctl.row_start = (col_ff == '0);
   assign item_ctl.last      = last;
   assign item_col           = col_ff;

   always_comb begin
      awaiting_in  = awaiting_ff;
      first_row_in = first_row_ff;
      col_in       = col_ff;
      filt_in      = filt_ff;
      if (in_accept) begin
         if (awaiting_eff) begin
            filt_in      = (in_byte > 8'(FILT_PAETH)) ? FILT_BAD
                                                      : psu_filt_type'(in_byte[2:0]);
            awaiting_in  = 1'b0;
            first_row_in = first_eff;
            col_in       = '0;
         end else if (last) begin
            col_in       = '0;
            awaiting_in  = 1'b1;
            first_row_in = 1'b0;
         end else begin
            col_in = col_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff  <= 1'b1;
         first_row_ff <= 1'b1;
         col_ff       <= '0;
         filt_ff      <= FILT_NONE;
      end else begin
         awaiting_ff  <= awaiting_in;
         first_row_ff <= first_row_in;
         col_ff       <= col_in;
         filt_ff      <= filt_in;
      end
   end

endmodule

// ----- hdl/psu_queue.sv -----
// ----------------------------------------------------------------------------
// PNG scanline unfilter - item queue
// Short first-in first-out buffer between front end and back end.
// ----------------------------------------------------------------------------
module psu_queue import psu_pkg::*; #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   localparam int PW = $clog2(PSU_QUEUE_DEPTH);
   localparam int CNTW = $clog2(PSU_QUEUE_DEPTH + 1);

   logic [W-1:0]    slot_ff [PSU_QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic            push, pop;

   assign in_ready  = count_ff != CNTW'(PSU_QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(PSU_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(PSU_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ----- hdl/psu_back.sv -----
// ----------------------------------------------------------------------------
// PNG scanline unfilter - back end
// Reads the line store, rebuilds each byte from its neighbors, writes it
// back and holds the result in the output register.
// ----------------------------------------------------------------------------
module psu_back import psu_pkg::*; #(
   parameter int MAX_ROW_BYTES   = PSU_MAX_ROW_BYTES,
   parameter int MAX_PIXEL_BYTES = PSU_MAX_PIXEL_BYTES,
   localparam int ADDR_W = $clog2(MAX_ROW_BYTES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [3:0]        bytes_per_pixel,
   input  logic              item_valid,
   output logic              item_ready,
   input  psu_ctl_type       item_ctl,
   input  logic [ADDR_W-1:0] item_col,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_byte,
   output logic              rsp_last,
   output logic              rsp_bad
);

   localparam int HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      logic signed [10:0] da, db, dc;
      logic [10:0]        pa, pb, pc;
      da = $signed({3'b000, b}) - $signed({3'b000, c});
      db = $signed({3'b000, a}) - $signed({3'b000, c});
      dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
      pa = (da < 0) ? 11'(-da) : 11'(da);
      pb = (db < 0) ? 11'(-db) : 11'(db);
      pc = (dc < 0) ? 11'(-dc) : 11'(dc);
      if (pa <= pb && pa <= pc) begin
         return a;
      end else if (pb <= pc) begin
         return b;
      end
      return c;
   endfunction

   logic [7:0] line_mem [MAX_ROW_BYTES];

   logic              s2_valid_ff;
   psu_ctl_type       s2_ctl_ff;
   logic [ADDR_W-1:0] s2_col_ff;
   logic [7:0]        rdata_ff;
   logic              fwd_ff;
   logic [7:0]        fwd_data_ff;

   logic [7:0] left_ff [MAX_PIXEL_BYTES];
   logic [7:0] uleft_ff [MAX_PIXEL_BYTES];
   logic [7:0] left_eff [MAX_PIXEL_BYTES];
   logic [7:0] uleft_eff [MAX_PIXEL_BYTES];

   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;
   logic       rsp_bad_ff;

   logic          out_free, s2_done, pop;
   logic [3:0]    bpp_eff;
   logic [HW-1:0] tap;
   logic [7:0]    a, b, c, b_mem, rebuilt;
   logic [8:0]    avg_sum;

   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign s2_done    = s2_valid_ff & out_free;
   assign item_ready = ~s2_valid_ff | s2_done;
   assign pop        = item_valid & item_ready;

   // clamp pixel size into 1..MAX_PIXEL_BYTES
   always_comb begin
      if (bytes_per_pixel == 4'd0) begin
         bpp_eff = 4'd1;
      end else if (bytes_per_pixel > 4'(MAX_PIXEL_BYTES)) begin
         bpp_eff = 4'(MAX_PIXEL_BYTES);
      end else begin
         bpp_eff = bytes_per_pixel;
      end
   end
   assign tap = HW'(bpp_eff - 4'd1);

   // histories read as zero on the first byte of a row
   always_comb begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
         left_eff[i]  = s2_ctl_ff.row_start ? 8'd0 : left_ff[i];
         uleft_eff[i] = s2_ctl_ff.row_start ? 8'd0 : uleft_ff[i];
      end
   end

   assign b_mem   = fwd_ff ? fwd_data_ff : rdata_ff;
   assign a       = left_eff[tap];
   assign b       = s2_ctl_ff.first_row ? 8'd0 : b_mem;
   assign c       = uleft_eff[tap];
   assign avg_sum = {1'b0, a} + {1'b0, b};

   always_comb begin
      case (s2_ctl_ff.filt)
         FILT_SUB:   rebuilt = s2_ctl_ff.data + a;
         FILT_UP:    rebuilt = s2_ctl_ff.data + b;
         FILT_AVG:   rebuilt = s2_ctl_ff.data + avg_sum[8:1];
         FILT_PAETH: rebuilt = s2_ctl_ff.data + paeth_pick(a, b, c);
         default:    rebuilt = s2_ctl_ff.data;
      endcase
   end

   // line store: read ahead for the next item, write the finished byte
   always_ff @(posedge clock) begin
      if (s2_done) begin
         line_mem[s2_col_ff] <= rebuilt;
      end
      if (pop) begin
         rdata_ff <= line_mem[item_col];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s2_ctl_ff   <= item_ctl;
         s2_col_ff   <= item_col;
         fwd_ff      <= s2_done & (s2_col_ff == item_col);
         fwd_data_ff <= rebuilt;
      end
      if (s2_done) begin
         left_ff[0]  <= rebuilt;
         uleft_ff[0] <= b;
         for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
            left_ff[i]  <= left_eff[i-1];
            uleft_ff[i] <= uleft_eff[i-1];
         end
         rsp_byte_ff <= rebuilt;
         rsp_last_ff <= s2_ctl_ff.last;
         rsp_bad_ff  <= (s2_ctl_ff.filt == FILT_BAD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_ready) begin
            s2_valid_ff <= item_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_bad   = rsp_bad_ff;

endmodule

// ----- hdl/png_scanline_unfilter.sv -----
// ----------------------------------------------------------------------------
// PNG scanline unfilter - top level
// Rebuilds PNG scanlines (None, Sub, Up, Average, Paeth) from an inflated
// byte stream, one byte per cycle while rsp_tready does not stall.
// ----------------------------------------------------------------------------
//
//   port group | dir | payload
//   -----------+-----+--------------------------------------------------------
//   req_*      | in  | tdata[7:0] in_byte, tuser[0] image_start
//   rsp_*      | out | tdata[7:0] pixel_byte, tlast row_end, tuser[0] bad_filter
//   csr_*      | in  | addr 0 bytes_per_pixel, addr 1 row_bytes, others ignored
//
// One byte per cycle sustained while rsp_tready stays high. A data byte
// passes the queue write, the line-store read and the output register before
// it shows on rsp_tvalid; filter-type bytes produce no transfer. The
// line-store read for each byte is issued as it leaves the queue, the rebuilt
// byte is written back as it leaves the rebuild stage, so the left-neighbor
// feedback closes through the left history registers for any pixel size.
// Reset is synchronous; the line store is not cleared. A stall on rsp_tready
// backs up into the two-entry queue and then drops req_tready.
//
module png_scanline_unfilter import psu_pkg::*; #(
   parameter int MAX_ROW_BYTES   = PSU_MAX_ROW_BYTES,
   parameter int MAX_PIXEL_BYTES = PSU_MAX_PIXEL_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   // input byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic [0:0]  req_tuser,   // [0] image_start
   // rebuilt byte stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] pixel_byte
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,   // [0] bad_filter
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
   localparam int CTL_W  = $bits(psu_ctl_type);
   localparam int QW     = CTL_W + ADDR_W;

   logic [3:0]  bpp_ff, bpp_in;
   logic [13:0] row_bytes_ff, row_bytes_in;

   logic              in_accept;
   logic              f_valid, f_ready;
   psu_ctl_type       f_ctl;
   logic [ADDR_W-1:0] f_col;
   logic              q_valid, q_ready;
   logic [QW-1:0]     q_data;
   psu_ctl_type       q_ctl;
   logic [ADDR_W-1:0] q_col;

   // configuration: always ready, unknown addresses drop the write
   assign csr_ready = 1'b1;

   always_comb begin
      bpp_in       = bpp_ff;
      row_bytes_in = row_bytes_ff;
      if (csr_valid) begin
         if (csr_addr == CSR_BYTES_PER_PIXEL) begin
            bpp_in = csr_wdata[3:0];
         end else if (csr_addr == CSR_ROW_BYTES) begin
            row_bytes_in = csr_wdata[13:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= BPP_RESET;
         row_bytes_ff <= ROW_BYTES_RESET;
      end else begin
         bpp_ff       <= bpp_in;
         row_bytes_ff <= row_bytes_in;
      end
   end

   // accept whenever the queue has room; filter bytes are consumed up front
   assign req_tready = f_ready;
   assign in_accept  = req_tvalid & req_tready;

   psu_front #(
      .MAX_ROW_BYTES (MAX_ROW_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .row_bytes   (row_bytes_ff),
      .in_accept   (in_accept),
      .in_byte     (req_tdata),
      .image_start (req_tuser[0]),
      .item_valid  (f_valid),
      .item_ctl    (f_ctl),
      .item_col    (f_col)
   );

   psu_queue #(
      .W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   ({f_col, f_ctl}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   assign q_ctl = q_data[CTL_W-1:0];
   assign q_col = q_data[QW-1:CTL_W];

   psu_back #(
      .MAX_ROW_BYTES   (MAX_ROW_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .bytes_per_pixel (bpp_ff),
      .item_valid      (q_valid),
      .item_ready      (q_ready),
      .item_ctl        (q_ctl),
      .item_col        (q_col),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_byte        (rsp_tdata),
      .rsp_last        (rsp_tlast),
      .rsp_bad         (rsp_tuser[0])
   );

endmodule

// ----- hdl/psu_checker.sv -----
// ----------------------------------------------------------------------------
// PNG scanline unfilter - port checker
// Watches the top-level ports for stall and reset behavior.
// ----------------------------------------------------------------------------
module psu_checker import psu_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic [0:0]  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp payload changed under stall");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // input backpressure only comes from a waiting result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with no result pending");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (.*);
